>>> rtl/sorted_priority_queue_unit_macros.svh
// Assertion helpers shared by the queue RTL.
`ifndef SORTED_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_MACROS_SVH

// Clocked check, off while reset is asserted.
`define SPQ_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define SPQ_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/spq_pkg.sv
package spq_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FPTR_W     = $clog2(FIFO_DEPTH);
  localparam int unsigned FCNT_W     = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_POP    = 2'd1,
    CMD_UPDATE = 2'd2,
    CMD_SEARCH = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef struct packed {
    cmd_e               op;
    logic signed [31:0] value;
    logic signed [31:0] prio;
    logic signed [31:0] new_value;
  } cmd_t;

  typedef struct packed {
    status_e            status;
    logic signed [31:0] out_value;
    logic signed [31:0] out_priority;
    logic [4:0]         entry_count;
  } result_t;

endpackage

>>> rtl/spq_front.sv
`include "sorted_priority_queue_unit_macros.svh"

module spq_front import spq_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic [1:0]   in_kind_i,
  input  logic [95:0]  in_data_i,
  output logic         cmd_valid_o,
  input  logic         cmd_ready_i,
  output cmd_t         cmd_o
);

  cmd_t              mem_q [FIFO_DEPTH];
  logic [FPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FCNT_W-1:0] fill_q, fill_d;
  cmd_t              word_in;
  logic              push, pop;

  always_comb begin
    word_in.op        = cmd_e'(in_kind_i);
    word_in.value     = in_data_i[31:0];
    word_in.prio      = in_data_i[63:32];
    word_in.new_value = in_data_i[95:64];
  end

  assign in_ready_o  = fill_q != FCNT_W'(FIFO_DEPTH);
  assign cmd_valid_o = fill_q != '0;
  assign cmd_o       = mem_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == FPTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + FPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == FPTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + FPTR_W'(1);
    end
    if (push && !pop) begin
      fill_d = fill_q + FCNT_W'(1);
    end else if (pop && !push) begin
      fill_d = fill_q - FCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= word_in;
    end
  end

  `SPQ_ASSERT(a_fill_bound, clk_i, rst_ni, fill_q <= FCNT_W'(FIFO_DEPTH), "queue overfilled")

endmodule

>>> rtl/spq_back.sv
`include "sorted_priority_queue_unit_macros.svh"

module spq_back import spq_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    cmd_valid_i,
  output logic    cmd_ready_o,
  input  cmd_t    cmd_i,
  output logic    res_valid_o,
  input  logic    res_ready_i,
  output result_t res_o
);

  logic signed [31:0] val_q [DEPTH];
  logic signed [31:0] pri_q [DEPTH];
  logic signed [31:0] val_d [DEPTH];
  logic signed [31:0] pri_d [DEPTH];
  logic [CNT_W-1:0]   count_q, count_d;
  logic               res_valid_q;
  result_t            res_q, res_d;

  logic [DEPTH-1:0]   live_v, le_v, match_v, first_v;
  logic               take, full, empty, hit, seen;
  logic signed [31:0] hit_val, hit_pri;

  assign cmd_ready_o = !res_valid_q || res_ready_i;
  assign take        = cmd_valid_i && cmd_ready_o;
  assign full        = count_q == CNT_W'(DEPTH);
  assign empty       = count_q == '0;

  // Every cell compares against the incoming word in parallel.
  always_comb begin
    seen    = 1'b0;
    hit_val = '0;
    hit_pri = '0;
    for (int i = 0; i < DEPTH; i++) begin
      live_v[i]  = CNT_W'(i) < count_q;
      le_v[i]    = live_v[i] && (pri_q[i] <= cmd_i.prio);
      match_v[i] = live_v[i] && (val_q[i] == cmd_i.value);
      first_v[i] = match_v[i] && !seen;
      seen       = seen || match_v[i];
      hit_val    = hit_val | (first_v[i] ? val_q[i] : '0);
      hit_pri    = hit_pri | (first_v[i] ? pri_q[i] : '0);
    end
    hit = seen;
  end

  always_comb begin
    count_d = count_q;
    res_d   = '{status: ST_OK, out_value: '0, out_priority: '0, entry_count: '0};
    for (int i = 0; i < DEPTH; i++) begin
      val_d[i] = val_q[i];
      pri_d[i] = pri_q[i];
    end
    case (cmd_i.op)
      CMD_INSERT: begin
        if (full) begin
          res_d.status = ST_FULL;
        end else begin
          // Cells at or below the slot shift toward the tail; stable after equal keys.
          for (int i = 0; i < DEPTH; i++) begin
            if (!le_v[i]) begin
              if (i == 0 || le_v[(i == 0) ? 0 : i - 1]) begin
                val_d[i] = cmd_i.value;
                pri_d[i] = cmd_i.prio;
              end else begin
                val_d[i] = val_q[(i == 0) ? 0 : i - 1];
                pri_d[i] = pri_q[(i == 0) ? 0 : i - 1];
              end
            end
          end
          count_d = count_q + CNT_W'(1);
        end
      end
      CMD_POP: begin
        if (empty) begin
          res_d.status = ST_EMPTY;
        end else begin
          res_d.out_value    = val_q[0];
          res_d.out_priority = pri_q[0];
          for (int i = 0; i < DEPTH - 1; i++) begin
            val_d[i] = val_q[i + 1];
            pri_d[i] = pri_q[i + 1];
          end
          count_d = count_q - CNT_W'(1);
        end
      end
      CMD_UPDATE: begin
        if (!hit) begin
          res_d.status = ST_NOTFOUND;
        end else begin
          for (int i = 0; i < DEPTH; i++) begin
            if (first_v[i]) begin
              val_d[i] = cmd_i.new_value;
            end
          end
        end
      end
      CMD_SEARCH: begin
        if (!hit) begin
          res_d.status = ST_NOTFOUND;
        end else begin
          res_d.out_value    = hit_val;
          res_d.out_priority = hit_pri;
        end
      end
      default: begin
        res_d.status = ST_OK;
      end
    endcase
    res_d.entry_count = 5'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (take) begin
        count_q <= count_d;
      end
      if (cmd_ready_o) begin
        res_valid_q <= cmd_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= res_d;
      for (int i = 0; i < DEPTH; i++) begin
        val_q[i] <= val_d[i];
        pri_q[i] <= pri_d[i];
      end
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  `SPQ_ASSERT_ALWAYS(a_count_bound, clk_i, count_q <= CNT_W'(DEPTH), "entry count overflow")
  `SPQ_ASSERT(a_head_sorted, clk_i, rst_ni, (count_q >= CNT_W'(2)) |-> (pri_q[0] <= pri_q[1]), "head out of order")
  `SPQ_ASSERT(a_insert_grows, clk_i, rst_ni, (take && cmd_i.op == CMD_INSERT && !full) |=> (count_q == $past(count_q) + CNT_W'(1)), "insert lost")
  `SPQ_ASSERT(a_full_refused, clk_i, rst_ni, (take && cmd_i.op == CMD_INSERT && full) |=> (res_q.status == ST_FULL && count_q == CNT_W'(DEPTH)), "full insert not refused")

endmodule

>>> rtl/sorted_priority_queue_unit.sv
// Channel   Dir  tuser               tdata
// s_axis    in   cmd                 value, priority_req, new_value
// m_axis    out  status              out_value, out_priority, entry_count
//
// One word per cycle sustained while m_axis_tready is high; a result word is registered in the back end
// after its command has passed through the front queue and been taken by the cell chain.
// Throughput is set by the cell chain, which compares all entries in parallel each cycle.
// A two-word queue sits between the command decode and the cell chain.
// Reset clears the entry count; cell contents stay undefined until written.
// A stalled result holds the chain, and the front keeps accepting until its queue fills.
module sorted_priority_queue_unit import spq_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [1:0]   s_axis_tuser,  // [1:0] cmd
  input  logic [95:0]  s_axis_tdata,  // [31:0] value, [63:32] priority_req, [95:64] new_value
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [1:0]   m_axis_tuser,  // [1:0] status
  output logic [71:0]  m_axis_tdata   // [31:0] out_value, [63:32] out_priority,
                                      // [68:64] entry_count, [71:69] zero
);

  logic    cmd_valid, cmd_ready;
  cmd_t    cmd;
  result_t res;

  spq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_kind_i   (s_axis_tuser),
    .in_data_i   (s_axis_tdata),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  spq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tuser = res.status;
  assign m_axis_tdata = {3'b000, res.entry_count, res.out_priority, res.out_value};

endmodule
